// ----- rtl/core/ctit_pkg.sv -----
// ---------------------------------------------------------------------------
// ctit_pkg
// Shared types and constants for the connection idle timeout table.
// ---------------------------------------------------------------------------
`default_nettype none

package ctit_pkg;

    localparam int unsigned ENTRIES       = 32;
    localparam int unsigned IDX_W         = $clog2(ENTRIES);
    localparam int unsigned ID_W          = 5;
    localparam int unsigned CMP_W         = ((ID_W > IDX_W) ? ID_W : IDX_W) + 1;
    localparam int unsigned TIME_W        = 32;
    localparam int unsigned TMO_W         = 31;
    localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(5000);

    typedef enum logic [1:0] {
        CMD_REFRESH = 2'd0,
        CMD_REMOVE  = 2'd1,
        CMD_SWEEP   = 2'd2
    } t_cmd;

    typedef enum logic {
        KIND_EXPIRED = 1'b0,
        KIND_REPORT  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_REPORT
    } t_state;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [ID_W-1:0]   conn_id;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic                     kind;
        logic [ID_W-1:0]          expired_id;
        logic signed [TIME_W-1:0] remaining_ms;
        logic                     last;
    } t_out_item;

    typedef struct packed {
        logic      load;
        t_out_item item;
    } t_res;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [TIME_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_ram_req;

endpackage

`default_nettype wire

// ----- rtl/core/connection_idle_timeout_table.sv -----
// ---------------------------------------------------------------------------
// connection_idle_timeout_table
// Per-connection idle timeout table with sweep and next-expiry report.
// ---------------------------------------------------------------------------
// Refresh and remove items are accepted back to back and produce no result.
// A sweep reads the expiry memory one entry at a time, with a memory read
// and then a compare and update for each entry, and holds the block longer
// while the output is stalled and an expired id or the final report waits.
// Input stall is high for the whole sweep. The armed flags live in flops and
// clear at reset; the expiry memory needs no clearing pass, so the block
// takes items right after reset.
// ---------------------------------------------------------------------------
`default_nettype none

module connection_idle_timeout_table (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire ctit_pkg::t_in_item          i_in_item,
    output logic                             o_in_stall,
    output logic                             o_out_valid,
    output ctit_pkg::t_out_item              o_out_item,
    input  wire logic                        i_out_stall,
    input  wire logic                        i_cfg_we,
    input  wire logic [ctit_pkg::TMO_W-1:0]  i_cfg_wdata
);

    ctit_pkg::t_res                  res;
    ctit_pkg::t_ram_req              ram_req;
    logic [ctit_pkg::TIME_W-1:0]     ram_rdata;
    logic                            out_free;
    logic                            r_out_valid;
    ctit_pkg::t_out_item             r_out_item;

    assign out_free = !r_out_valid || !i_out_stall;

    ctit_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_free  (out_free),
        .o_res       (res),
        .o_ram_req   (ram_req),
        .i_ram_rdata (ram_rdata)
    );

    ctit_ram #(
        .DEPTH (ctit_pkg::ENTRIES),
        .AW    (ctit_pkg::IDX_W),
        .DW    (ctit_pkg::TIME_W)
    ) u_expiry_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.load) begin
            r_out_item <= res.item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

`default_nettype wire

// ----- rtl/core/ctit_ram.sv -----
// ---------------------------------------------------------------------------
// ctit_ram
// Simple dual-port synchronous RAM with registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module ctit_ram #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5,
    parameter int unsigned DW    = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ctit_ctrl.sv -----
// ---------------------------------------------------------------------------
// ctit_ctrl
// Command sequencer: refresh/remove updates, sweep over the expiry memory.
// ---------------------------------------------------------------------------
`default_nettype none

module ctit_ctrl (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire ctit_pkg::t_in_item             i_in_item,
    output logic                                o_in_stall,
    input  wire logic                           i_cfg_we,
    input  wire logic [ctit_pkg::TMO_W-1:0]     i_cfg_wdata,
    input  wire logic                           i_out_free,
    output ctit_pkg::t_res                      o_res,
    output ctit_pkg::t_ram_req                  o_ram_req,
    input  wire logic [ctit_pkg::TIME_W-1:0]    i_ram_rdata
);

    ctit_pkg::t_state                   r_state;
    ctit_pkg::t_state                   n_state;
    logic [ctit_pkg::ENTRIES-1:0]       r_armed;
    logic [ctit_pkg::IDX_W-1:0]         r_idx;
    logic [ctit_pkg::TIME_W-1:0]        r_now;
    logic [ctit_pkg::TMO_W-1:0]         r_best;
    logic                               r_any;
    logic [ctit_pkg::TMO_W-1:0]         r_timeout;

    logic                               accept;
    logic                               id_ok;
    logic [ctit_pkg::IDX_W-1:0]         in_idx;
    logic [ctit_pkg::TIME_W-1:0]        diff;
    logic                               expired;
    logic                               armed_cur;
    logic                               last_idx;
    logic                               step;
    logic                               disarm;
    logic                               upd_best;

    assign accept    = i_in_valid && (r_state == ctit_pkg::ST_IDLE);
    assign id_ok     = (ctit_pkg::CMP_W'(i_in_item.conn_id) <
                        ctit_pkg::CMP_W'(ctit_pkg::ENTRIES));
    assign in_idx    = ctit_pkg::IDX_W'(i_in_item.conn_id);
    assign diff      = i_ram_rdata - r_now;
    assign expired   = (diff == '0) || diff[ctit_pkg::TIME_W-1];
    assign armed_cur = r_armed[r_idx];
    assign last_idx  = (r_idx == ctit_pkg::IDX_W'(ctit_pkg::ENTRIES - 1));
    assign step      = !armed_cur || !expired || i_out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ctit_pkg::ST_IDLE: begin
                if (accept && (i_in_item.cmd == ctit_pkg::CMD_SWEEP)) begin
                    n_state = ctit_pkg::ST_READ;
                end
            end
            ctit_pkg::ST_READ: begin
                n_state = ctit_pkg::ST_EVAL;
            end
            ctit_pkg::ST_EVAL: begin
                if (step) begin
                    n_state = last_idx ? ctit_pkg::ST_REPORT : ctit_pkg::ST_READ;
                end
            end
            ctit_pkg::ST_REPORT: begin
                if (i_out_free) begin
                    n_state = ctit_pkg::ST_IDLE;
                end
            end
            default: n_state = ctit_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall          = 1'b1;
        o_ram_req.we        = 1'b0;
        o_ram_req.waddr     = in_idx;
        o_ram_req.wdata     = i_in_item.now_ms + ctit_pkg::TIME_W'(r_timeout);
        o_ram_req.re        = 1'b0;
        o_ram_req.raddr     = r_idx;
        o_res.load          = 1'b0;
        o_res.item.kind     = ctit_pkg::KIND_EXPIRED;
        o_res.item.expired_id   = ctit_pkg::ID_W'(r_idx);
        o_res.item.remaining_ms = '0;
        o_res.item.last     = 1'b0;
        disarm              = 1'b0;
        upd_best            = 1'b0;
        unique case (r_state)
            ctit_pkg::ST_IDLE: begin
                o_in_stall   = 1'b0;
                o_ram_req.we = accept && id_ok &&
                               (i_in_item.cmd == ctit_pkg::CMD_REFRESH);
            end
            ctit_pkg::ST_READ: begin
                o_ram_req.re = 1'b1;
            end
            ctit_pkg::ST_EVAL: begin
                disarm     = armed_cur && expired && i_out_free;
                o_res.load = disarm;
                upd_best   = armed_cur && !expired &&
                             (!r_any || (diff[ctit_pkg::TMO_W-1:0] < r_best));
            end
            ctit_pkg::ST_REPORT: begin
                o_res.load              = i_out_free;
                o_res.item.kind         = ctit_pkg::KIND_REPORT;
                o_res.item.expired_id   = '0;
                o_res.item.remaining_ms = r_any ? {1'b0, r_best} : '1;
                o_res.item.last         = 1'b1;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ctit_pkg::ST_IDLE;
            r_armed   <= '0;
            r_any     <= 1'b0;
            r_idx     <= '0;
            r_timeout <= ctit_pkg::TIMEOUT_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (accept && id_ok) begin
                if (i_in_item.cmd == ctit_pkg::CMD_REFRESH) begin
                    r_armed[in_idx] <= 1'b1;
                end else if (i_in_item.cmd == ctit_pkg::CMD_REMOVE) begin
                    r_armed[in_idx] <= 1'b0;
                end
            end
            if (disarm) begin
                r_armed[r_idx] <= 1'b0;
            end
            if (accept && (i_in_item.cmd == ctit_pkg::CMD_SWEEP)) begin
                r_idx <= '0;
                r_any <= 1'b0;
            end else if ((r_state == ctit_pkg::ST_EVAL) && step && !last_idx) begin
                r_idx <= r_idx + 1'b1;
            end
            if (upd_best) begin
                r_any <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_now <= i_in_item.now_ms;
        end
        if (upd_best) begin
            r_best <= diff[ctit_pkg::TMO_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ctit_checker.sv -----
// ---------------------------------------------------------------------------
// ctit_checker
// Port-level checks for the connection idle timeout table.
// ---------------------------------------------------------------------------
`default_nettype none

module ctit_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        i_in_valid,
    input wire ctit_pkg::t_in_item          i_in_item,
    input wire logic                        o_in_stall,
    input wire logic                        o_out_valid,
    input wire ctit_pkg::t_out_item         o_out_item,
    input wire logic                        i_out_stall
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled output item changed");

    a_sweep_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_item.cmd == ctit_pkg::CMD_SWEEP)
        |=> o_in_stall)
        else $error("input not stalled after sweep accept");

    a_expired_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.kind == ctit_pkg::KIND_EXPIRED) |-> o_in_stall)
        else $error("expired id shown outside a sweep");

    a_expired_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_item.kind == ctit_pkg::KIND_EXPIRED)
        |-> !o_out_item.last && (o_out_item.remaining_ms == '0))
        else $error("expired id item has report fields set");

endmodule

bind connection_idle_timeout_table ctit_checker u_ctit_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .i_in_item   (i_in_item),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .o_out_item  (o_out_item),
    .i_out_stall (i_out_stall)
);

`default_nettype wire

// ----- tb/ctit_tb_pkg.sv -----
// ---------------------------------------------------------------------------
// ctit_tb_pkg
// Expiry tracker for the connection idle timeout table testbench. It keeps
// its own armed flags, expiry times and timeout, works out the ids and the
// next-timeout report that each accepted sweep must produce, and checks every
// result from the block against the oldest one still due.
// ---------------------------------------------------------------------------
`default_nettype none

package ctit_tb_pkg;

    import ctit_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    class expiry_tracker;

        bit                armed [ENTRIES];
        logic [TIME_W-1:0] expiry [ENTRIES];
        logic [TMO_W-1:0]  tmo;
        t_out_item         due_results [$];
        int                mismatches;
        int                items;
        int                sweeps;
        int                expired_ids;

        function new();
            tmo = TIMEOUT_RESET;
            foreach (armed[i]) begin
                armed[i]  = 1'b0;
                expiry[i] = '0;
            end
            mismatches  = 0;
            items       = 0;
            sweeps      = 0;
            expired_ids = 0;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH: %s", msg);
            mismatches++;
        endtask

        function void queue_due(t_out_item r);
            due_results.insert(due_results.size(), r);
        endfunction

        function void note_item(t_in_item it);
            logic [TIME_W-1:0] diff;
            logic [TIME_W-1:0] best;
            bit                any;
            t_out_item         r;
            items++;
            any  = 1'b0;
            best = '0;
            case (it.cmd)
                CMD_REFRESH: begin
                    if (it.conn_id < ENTRIES) begin
                        armed[it.conn_id]  = 1'b1;
                        expiry[it.conn_id] = it.now_ms + {1'b0, tmo};
                    end
                end
                CMD_REMOVE: begin
                    if (it.conn_id < ENTRIES)
                        armed[it.conn_id] = 1'b0;
                end
                CMD_SWEEP: begin
                    sweeps++;
                    for (int i = 0; i < ENTRIES; i++) begin
                        if (armed[i]) begin
                            diff = expiry[i] - it.now_ms;
                            if (diff == '0 || diff[TIME_W-1]) begin
                                armed[i]       = 1'b0;
                                r.kind         = KIND_EXPIRED;
                                r.expired_id   = ID_W'(i);
                                r.remaining_ms = '0;
                                r.last         = 1'b0;
                                queue_due(r);
                                expired_ids++;
                            end else begin
                                if (!any || diff < best)
                                    best = diff;
                                any = 1'b1;
                            end
                        end
                    end
                    r.kind         = KIND_REPORT;
                    r.expired_id   = '0;
                    r.remaining_ms = any ? best : '1;
                    r.last         = 1'b1;
                    queue_due(r);
                end
                default: begin
                end
            endcase
        endfunction

        task check_result(t_out_item got);
            t_out_item want;
            if (due_results.size() == 0) begin
                report_mismatch($sformatf("result with none due: kind=%0d id=%0d rem=%0d last=%0d",
                                          got.kind, got.expired_id, got.remaining_ms,
                                          got.last));
                return;
            end
            want = due_results.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.expired_id !== want.expired_id)
                report_mismatch($sformatf("expired_id %0d, want %0d",
                                          got.expired_id, want.expired_id));
            if (got.remaining_ms !== want.remaining_ms)
                report_mismatch($sformatf("remaining_ms %0d, want %0d",
                                          got.remaining_ms, want.remaining_ms));
            if (got.last !== want.last)
                report_mismatch($sformatf("last %0d, want %0d", got.last, want.last));
        endtask

    endclass

endpackage

`default_nettype wire

// ----- tb/tb_top.sv -----
// ---------------------------------------------------------------------------
// tb_top
// Testbench for the connection idle timeout table. A directed run covers the
// empty sweep, ids at both ends, remove, the unused command, expiry exactly
// at now and the signed wrap boundary; random traffic of refreshes, removes
// and sweeps over a moving clock follows under several timeout settings,
// zero and the largest among them, with random gaps and output stalls.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import ctit_pkg::*;
    import ctit_tb_pkg::*;

    localparam int SETTLE       = 2 * ENTRIES + 8;
    localparam int LIMIT        = 3000000;
    localparam int PHASE_ITEMS  = 60;
    localparam int PHASES       = 6;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    t_in_item           i_in_item   = '0;
    logic               o_in_stall;
    logic               o_out_valid;
    t_out_item          o_out_item;
    logic               i_out_stall = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [TMO_W-1:0]   i_cfg_wdata = '0;

    expiry_tracker      sb;
    bit                 quiet;
    logic [TIME_W-1:0]  cur_ms;
    logic [TMO_W-1:0]   tmo_plan [PHASES];

    connection_idle_timeout_table DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic t_in_item item_of(logic [1:0] cmd, int id, logic [TIME_W-1:0] now);
        t_in_item it;
        it.cmd     = cmd;
        it.conn_id = ID_W'(id);
        it.now_ms  = now;
        return it;
    endfunction

    task automatic send_item(t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(it);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_timeout(logic [TMO_W-1:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.tmo = v;
    endtask

    task automatic run_directed();
        send_item(item_of(CMD_SWEEP,   0,  32'd0));
        send_item(item_of(CMD_REFRESH, 0,  32'd0));
        send_item(item_of(CMD_REFRESH, 31, 32'hFFFF_FFFF));
        send_item(item_of(CMD_REFRESH, 5,  32'd100));
        send_item(item_of(CMD_REMOVE,  5,  32'd100));
        send_item(item_of(CMD_UNUSED,  5,  32'h1234_5678));
        send_item(item_of(CMD_REMOVE,  9,  32'd0));
        send_item(item_of(CMD_SWEEP,   0,  32'd4999));
        send_item(item_of(CMD_SWEEP,   31, 32'd5000));
        send_item(item_of(CMD_REFRESH, 7,  32'd0));
        send_item(item_of(CMD_REFRESH, 8,  32'd1));
        send_item(item_of(CMD_SWEEP,   0,  32'h8000_1389));
        send_item(item_of(CMD_REFRESH, 31, 32'hFFFF_FFFF));
        send_item(item_of(CMD_REFRESH, 16, 32'h8000_0000));
        send_item(item_of(CMD_REFRESH, 15, 32'h7FFF_FFFF));
        send_item(item_of(CMD_UNUSED,  31, 32'hFFFF_FFFF));
        send_item(item_of(CMD_SWEEP,   21, 32'h0000_1387));
        send_item(item_of(CMD_SWEEP,   10, 32'hFFFF_FFFF));
        send_item(item_of(CMD_REMOVE,  31, 32'hFFFF_FFFF));
        send_item(item_of(CMD_SWEEP,   0,  32'hFFFF_FFFF));
        cur_ms = 32'd0;
    endtask

    task automatic run_traffic(int n);
        int                r;
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] now;
        logic [1:0]        cmd;
        for (int k = 0; k < n; k++) begin
            span = (sb.tmo < 8) ? 32'd8 : {1'b0, sb.tmo} / 3;
            r = $urandom_range(0, 99);
            if (r < 12)
                now = cur_ms;
            else if (r < 95)
                now = cur_ms + $urandom_range(0, span);
            else
                now = cur_ms + $urandom;
            r = $urandom_range(0, 99);
            if (r < 48)
                cmd = CMD_REFRESH;
            else if (r < 63)
                cmd = CMD_REMOVE;
            else if (r < 94)
                cmd = CMD_SWEEP;
            else
                cmd = CMD_UNUSED;
            if ($urandom_range(0, 19) == 0)
                send_item(item_of(cmd, $urandom_range(0, 31), $urandom));
            else begin
                cur_ms = now;
                send_item(item_of(cmd, $urandom_range(0, 31), now));
            end
        end
        send_item(item_of(CMD_SWEEP, $urandom_range(0, 31), cur_ms + span));
        cur_ms = cur_ms + span;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_out_item);
    end

    initial begin
        int n;
        forever begin
            n = pick_gap();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
    end

    initial begin
        repeat (LIMIT) @(posedge i_clk);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        sb     = new();
        quiet  = 1'b0;
        cur_ms = '0;
        tmo_plan[0] = '0;
        tmo_plan[1] = TMO_W'(1);
        tmo_plan[2] = '1;
        tmo_plan[3] = TMO_W'(5000);
        tmo_plan[4] = TMO_W'($urandom_range(2, 20000));
        tmo_plan[5] = TMO_W'($urandom);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        foreach (tmo_plan[p]) begin
            set_timeout(tmo_plan[p]);
            quiet = ($urandom_range(0, 3) == 0);
            run_traffic(PHASE_ITEMS);
        end
        quiet = 1'b0;
        drain();

        $display("Covered %0d items, %0d sweeps and %0d expired ids", sb.items, sb.sweeps,
                 sb.expired_ids);
        $display("over %0d timeout settings including zero and the largest value; %0d mismatches",
                 PHASES, sb.mismatches);
        if (sb.mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
